### hw/rtl/pcx_rle_pkg.sv
// Shared constants, byte classes and controller/datapath interface types of the PCX decoder.
package pcx_rle_pkg;

  localparam int HEADER_BYTES  = 128;
  localparam int PALETTE_BYTES = 768;
  localparam int PAL_ENTRIES   = PALETTE_BYTES / 3;

  localparam logic [23:0] POS_MAX      = 24'hFFFFFF;
  localparam logic [11:0] ROW_MAX      = 12'd4095;
  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [7:0]  RUN_MIN_BYTE = 8'd192;

  // Configuration register indexes
  localparam logic CFG_IMAGE_WIDTH = 1'b0;
  localparam logic CFG_FILE_LENGTH = 1'b1;

  // Result kinds carried in tuser
  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_PALETTE = 1'b1;

  // Classes of the byte held for decoding
  localparam logic [2:0] CLS_SKIP  = 3'd0;
  localparam logic [2:0] CLS_COLOR = 3'd1;
  localparam logic [2:0] CLS_RUN   = 3'd2;
  localparam logic [2:0] CLS_LIT   = 3'd3;
  localparam logic [2:0] CLS_PHOLD = 3'd4;
  localparam logic [2:0] CLS_PEMIT = 3'd5;

  typedef struct packed {
    logic load_byte;
    logic pos_adv;
    logic set_run;
    logic clr_await;
    logic emit_pixel;
    logic run_dec;
    logic pal_hold;
    logic pal_emit;
  } pcx_cmd_t;

  typedef struct packed {
    logic [2:0] cls;
    logic       run_zero;
    logic       run_one;
    logic       out_free;
  } pcx_sts_t;

endpackage

### hw/rtl/pcx_rle_image_decoder_core.sv
// Top level of the 8-bit PCX run-length image decoder with palette trailer.
// Each byte is registered when accepted; its result is written to the output register in its decode step.
// Header, literal, run-marker and palette bytes each pass through an accept step and a decode step;
//   a run colour byte is accepted and then emits its N >= 1 pixels, one pixel per cycle from the pixel
//   datapath while the output is free; an empty run passes through accept and decode only.
// Output stalls hold the decode; the next byte is still taken while a result waits.
// Reset (rst_ni low, asynchronous) clears all decode state; image_width returns to 640,
//   file_length to 0. No clearing pass is needed.
module pcx_rle_image_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration writes: index 0 image_width, index 1 file_length
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [23:0] cfg_wdata_i,
  // Input stream of file bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] file_byte
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [11:0] pixel_x, [23:12] pixel_y, [31:24] pixel_color, [39:32] palette_index,
  // [45:40] dac_red, [51:46] dac_green, [57:52] dac_blue, [63:58] zero
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] item_kind (0 pixel, 1 palette entry)
  output logic        m_axis_tlast    // run_last: last result of its input byte
);

  pcx_rle_pkg::pcx_cmd_t cmd;
  pcx_rle_pkg::pcx_sts_t sts;

  // Sequencing: take a byte, classify it, then emit zero, one or a run of results
  pcx_rle_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // Decode state, position counters, palette collector and output register
  pcx_rle_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

### hw/rtl/pcx_rle_dp.sv
// Datapath of the PCX decoder: byte register, decode state, palette collector, output register.
module pcx_rle_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_addr_i,
  input  logic [23:0]         cfg_wdata_i,
  input  logic [7:0]          s_axis_tdata,
  input  logic                m_axis_tready,
  output logic                m_axis_tvalid,
  output logic [63:0]         m_axis_tdata,
  output logic                m_axis_tuser,
  output logic                m_axis_tlast,
  input  pcx_rle_pkg::pcx_cmd_t cmd_i,
  output pcx_rle_pkg::pcx_sts_t sts_o
);

  logic [11:0] width_q;
  logic [23:0] flen_q;
  logic [7:0]  byte_q;
  logic [23:0] pos_q;
  logic [11:0] col_q, col_d;
  logic [11:0] row_q, row_d;
  logic [5:0]  pend_q;
  logic        await_q;
  logic [15:0] hold_q;
  logic [1:0]  phase_q;
  logic [7:0]  entry_q;
  logic        full_q;

  logic        ovalid_q;
  logic        okind_q;
  logic        olast_q;
  logic [11:0] ox_q, oy_q;
  logic [7:0]  ocolor_q, oidx_q;
  logic [5:0]  ored_q, ogreen_q, oblue_q;

  logic        in_header;
  logic        in_image;
  logic [11:0] col_inc;
  logic        pal_last;
  logic [2:0]  byte_cls;

  assign in_header = pos_q < 24'(pcx_rle_pkg::HEADER_BYTES);
  assign in_image  = ({1'b0, pos_q} + 25'(pcx_rle_pkg::PALETTE_BYTES)) < {1'b0, flen_q};
  assign pal_last  = ({1'b0, entry_q} + 9'd1) >= 9'(pcx_rle_pkg::PAL_ENTRIES);

  always_comb begin
    if (await_q) begin
      byte_cls = pcx_rle_pkg::CLS_COLOR;
    end else if (in_header) begin
      byte_cls = pcx_rle_pkg::CLS_SKIP;
    end else if (in_image) begin
      byte_cls = (byte_q >= pcx_rle_pkg::RUN_MIN_BYTE) ? pcx_rle_pkg::CLS_RUN
                                                       : pcx_rle_pkg::CLS_LIT;
    end else if (!full_q) begin
      byte_cls = (phase_q < 2'd2) ? pcx_rle_pkg::CLS_PHOLD : pcx_rle_pkg::CLS_PEMIT;
    end else begin
      byte_cls = pcx_rle_pkg::CLS_SKIP;
    end
  end

  assign sts_o = '{cls:      byte_cls,
                   run_zero: (pend_q == 6'd0),
                   run_one:  (pend_q == 6'd1),
                   out_free: (!ovalid_q || m_axis_tready)};

  // Next pixel position: wrap at the configured width, saturate the row
  assign col_inc = col_q + 12'd1;
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.emit_pixel) begin
      if (col_inc >= width_q) begin
        col_d = '0;
        if (row_q < pcx_rle_pkg::ROW_MAX) begin
          row_d = row_q + 12'd1;
        end
      end else begin
        col_d = col_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= pcx_rle_pkg::WIDTH_RESET;
      flen_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        pcx_rle_pkg::CFG_IMAGE_WIDTH: width_q <= cfg_wdata_i[11:0];
        pcx_rle_pkg::CFG_FILE_LENGTH: flen_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) begin
      byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      pend_q  <= '0;
      await_q <= 1'b0;
      hold_q  <= '0;
      phase_q <= '0;
      entry_q <= '0;
      full_q  <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cmd_i.pos_adv && pos_q != pcx_rle_pkg::POS_MAX) begin
        pos_q <= pos_q + 24'd1;
      end
      if (cmd_i.set_run) begin
        pend_q  <= byte_q[5:0];
        await_q <= 1'b1;
      end else if (cmd_i.run_dec) begin
        pend_q <= pend_q - 6'd1;
      end
      if (cmd_i.clr_await) begin
        await_q <= 1'b0;
      end
      if (cmd_i.pal_hold) begin
        hold_q  <= {hold_q[7:0], byte_q};
        phase_q <= phase_q + 2'd1;
      end else if (cmd_i.pal_emit) begin
        hold_q  <= '0;
        phase_q <= '0;
        entry_q <= entry_q + 8'd1;
        if (pal_last) begin
          full_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit_pixel || cmd_i.pal_emit) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_pixel) begin
      okind_q  <= pcx_rle_pkg::KIND_PIXEL;
      olast_q  <= cmd_i.run_dec ? sts_o.run_one : 1'b1;
      ox_q     <= col_q;
      oy_q     <= row_q;
      ocolor_q <= byte_q;
      oidx_q   <= '0;
      ored_q   <= '0;
      ogreen_q <= '0;
      oblue_q  <= '0;
    end else if (cmd_i.pal_emit) begin
      okind_q  <= pcx_rle_pkg::KIND_PALETTE;
      olast_q  <= 1'b1;
      ox_q     <= '0;
      oy_q     <= '0;
      ocolor_q <= '0;
      oidx_q   <= entry_q;
      ored_q   <= hold_q[15:10];
      ogreen_q <= hold_q[7:2];
      oblue_q  <= byte_q[7:2];
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {6'b0, oblue_q, ogreen_q, ored_q, oidx_q, ocolor_q, oy_q, ox_q};

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_pixel || cmd_i.pal_emit) |-> (!ovalid_q || m_axis_tready))
    else $error("result emitted over a waiting transaction");

endmodule

### hw/rtl/pcx_rle_ctrl.sv
// Controller state machine of the PCX decoder: accept, decode and run expansion sequencing.
module pcx_rle_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  pcx_rle_pkg::pcx_sts_t sts_i,
  output pcx_rle_pkg::pcx_cmd_t cmd_o
);

  localparam logic [1:0] ST_WAIT   = 2'd0;
  localparam logic [1:0] ST_DECODE = 2'd1;
  localparam logic [1:0] ST_RUN    = 2'd2;

  logic [1:0] state_q, state_d;
  logic       is_color, need_out, go;

  assign is_color = (sts_i.cls == pcx_rle_pkg::CLS_COLOR);
  assign need_out = (sts_i.cls == pcx_rle_pkg::CLS_LIT) ||
                    (sts_i.cls == pcx_rle_pkg::CLS_PEMIT) ||
                    (is_color && !sts_i.run_zero);

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    go            = 1'b0;
    case (state_q)
      ST_WAIT: begin
        s_axis_tready   = 1'b1;
        cmd_o.load_byte = s_axis_tvalid;
        if (s_axis_tvalid) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        go = !need_out || sts_i.out_free;
        if (go) begin
          cmd_o.pos_adv    = 1'b1;
          cmd_o.set_run    = (sts_i.cls == pcx_rle_pkg::CLS_RUN);
          cmd_o.clr_await  = is_color;
          cmd_o.emit_pixel = (sts_i.cls == pcx_rle_pkg::CLS_LIT) ||
                             (is_color && !sts_i.run_zero);
          cmd_o.run_dec    = is_color && !sts_i.run_zero;
          cmd_o.pal_hold   = (sts_i.cls == pcx_rle_pkg::CLS_PHOLD);
          cmd_o.pal_emit   = (sts_i.cls == pcx_rle_pkg::CLS_PEMIT);
          state_d = (is_color && !sts_i.run_zero && !sts_i.run_one) ? ST_RUN : ST_WAIT;
        end
      end
      ST_RUN: begin
        if (sts_i.out_free) begin
          cmd_o.emit_pixel = 1'b1;
          cmd_o.run_dec    = 1'b1;
          if (sts_i.run_one) begin
            state_d = ST_WAIT;
          end
        end
      end
      default: begin
        state_d = ST_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WAIT;
    end else begin
      state_q <= state_d;
    end
  end

  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> !sts_i.run_zero)
    else $error("run expansion with no pixels left");

  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.set_run, cmd_o.emit_pixel, cmd_o.pal_hold, cmd_o.pal_emit}))
    else $error("conflicting datapath commands");

  a_pos_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pos_adv |=> (state_q != ST_DECODE))
    else $error("byte position advanced without leaving decode");

  a_dec_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.run_dec |-> cmd_o.emit_pixel)
    else $error("run count decremented without a pixel");

endmodule
